[hw/rtl/ptt_pkg.sv]
// Package for the periodic timer table: shared constants, codes and payload types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ptt_pkg;

   // Default table depth and front queue depth (queue depth is a power of two)
   localparam int NUM_TIMERS_DEFAULT = 8;
   localparam int QUEUE_DEPTH        = 2;

   // Input opcodes
   localparam logic [1:0] OP_SET      = 2'd0;
   localparam logic [1:0] OP_REMOVE   = 2'd1;
   localparam logic [1:0] OP_TICK     = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_FIRED  = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;

   // Command status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DISABLED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  timer_id;
      logic [31:0] period;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] status;
      logic [7:0] fired_id;
      logic       last;
   } rsp_type;

   // Command handed from the front queue to the execution engine
   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  timer_id;
      logic [31:0] period;
   } cmd_type;

endpackage

[hw/rtl/periodic_timer_table_unit.sv]
// Periodic timer table, top level: ties the request front end to the
// execution back end. Depends on ptt_pkg, ptt_front and ptt_back.
//
// Usage:
//   req_* carries commands (set timer, remove timer, tick) as valid/ready
//   transactions; rsp_* returns results the same way. A set or remove gives
//   one status result; a tick gives one fired result per expiring timer in
//   table order, then one done result. The last result of a command has last=1.
//   Opcode 3 is accepted and dropped with no result.
//   csr_write_en/csr_write_data write timers_enabled (1 after reset); write it
//   only while no command is outstanding.
// Throughput:
//   A two-entry command queue sits before the back end. The back end takes
//   one command at a time: set and remove search the table one entry per
//   cycle, remove then shifts later entries down one per cycle, and tick
//   visits one entry per cycle while no fired result waits on a held
//   response on rsp_*. The single table read port sets this pace.
// Reset: the table is empty and the queue and response register are cleared.
// Stalls: a held response stalls the back end only when it has a new result
//   to show; the queue keeps accepting requests until it is full.
`timescale 1ns / 1ps

module periodic_timer_table_unit #(
   parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ptt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ptt_pkg::rsp_type rsp_payload,
   input  logic             csr_write_en,
   input  logic             csr_write_data
);
   import ptt_pkg::*;

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd_payload;

   ptt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd_payload (cmd_payload)
   );

   ptt_back #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd_payload    (cmd_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload)
   );

   // Status is only nonzero on status results
   a_status_only_on_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind != KIND_STATUS) |-> rsp_payload.status == STATUS_OK)
      else $error("status set on a non-status result");

   // Fired results never close a transaction; status and done always do
   a_last_marking: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last == (rsp_payload.kind != KIND_FIRED)))
      else $error("last flag does not match result kind");

   // A queued command not taken stays queued
   a_queue_holds: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && !cmd_ready |=> cmd_valid)
      else $error("queued command lost");

   // A full queue always presents a command to the back end
   a_full_has_head: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> cmd_valid)
      else $error("queue full without a head entry");

endmodule

[hw/rtl/ptt_front.sv]
// Front end of the timer table: accepts request transactions, drops reserved
// opcodes and queues commands for the back end. Depends on ptt_pkg.
`timescale 1ns / 1ps

module ptt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ptt_pkg::req_type req_payload,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output ptt_pkg::cmd_type cmd_payload
);
   import ptt_pkg::*;

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               push, pop;
   cmd_type            cmd_new;

   // Classify: reserved opcodes are taken and dropped
   always_comb begin
      cmd_new.op       = req_payload.opcode;
      cmd_new.timer_id = req_payload.timer_id;
      cmd_new.period   = req_payload.period;
   end

   assign req_ready   = (fill_ff != FILL_W'(QUEUE_DEPTH));
   assign push        = req_valid && req_ready && (req_payload.opcode != OP_RESERVED);
   assign cmd_valid   = (fill_ff != '0);
   assign pop         = cmd_valid && cmd_ready;
   assign cmd_payload = queue_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

[hw/rtl/ptt_back.sv]
// Back end of the timer table: holds the packed timer entries, runs set,
// remove and tick commands, and drives the response register. Depends on ptt_pkg.
`timescale 1ns / 1ps

module ptt_back #(
   parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic             csr_write_data,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  ptt_pkg::cmd_type cmd_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ptt_pkg::rsp_type rsp_payload
);
   import ptt_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);

   typedef struct packed {
      logic [7:0]  timer_id;
      logic [31:0] countdown;
      logic [31:0] reload;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_TICK,
      ST_DONE,
      ST_STATUS
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   cmd_type            cmd_ff, cmd_in;
   logic [1:0]         status_ff, status_in;
   logic               enabled_ff, enabled_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   entry_type          table_ff [NUM_TIMERS];
   logic [CNT_W-1:0]   idx_plus;
   logic [CNT_W-1:0]   rd_addr;
   entry_type          rd_entry;
   logic               mem_we;
   logic [CNT_W-1:0]   mem_waddr;
   entry_type          mem_wdata;
   logic               out_free;
   logic               emit;
   rsp_type            emit_data;

   assign idx_plus = idx_ff + CNT_W'(1);
   // Shift reads the next entry, every other state reads the current one
   assign rd_addr  = (state_ff == ST_SHIFT) ? idx_plus : idx_ff;
   assign rd_entry = table_ff[rd_addr[IDX_W-1:0]];
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Command sequencer
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      cmd_in     = cmd_ff;
      status_in  = status_ff;
      enabled_in = csr_write_en ? csr_write_data : enabled_ff;
      cmd_ready  = 1'b0;
      emit       = 1'b0;
      emit_data  = '0;
      mem_we     = 1'b0;
      mem_waddr  = idx_ff;
      mem_wdata  = rd_entry;

      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in = cmd_payload;
               idx_in = '0;
               if (cmd_payload.op == OP_TICK) begin
                  state_in = ST_TICK;
               end else if (!enabled_ff) begin
                  status_in = STATUS_DISABLED;
                  state_in  = ST_STATUS;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end

         // Linear id search over the valid entries
         ST_SEARCH: begin
            if (idx_ff == count_ff) begin
               status_in = STATUS_OK;
               state_in  = ST_STATUS;
               if (cmd_ff.op == OP_SET) begin
                  if (count_ff < CNT_W'(NUM_TIMERS)) begin
                     mem_we              = 1'b1;
                     mem_waddr           = count_ff;
                     mem_wdata.timer_id  = cmd_ff.timer_id;
                     mem_wdata.countdown = cmd_ff.period;
                     mem_wdata.reload    = cmd_ff.period;
                     count_in            = count_ff + CNT_W'(1);
                  end else begin
                     status_in = STATUS_FULL;
                  end
               end
            end else if (rd_entry.timer_id == cmd_ff.timer_id) begin
               if (cmd_ff.op == OP_SET) begin
                  mem_we              = 1'b1;
                  mem_wdata.countdown = cmd_ff.period;
                  mem_wdata.reload    = cmd_ff.period;
                  status_in           = STATUS_OK;
                  state_in            = ST_STATUS;
               end else begin
                  state_in = ST_SHIFT;
               end
            end else begin
               idx_in = idx_plus;
            end
         end

         // Close the gap left by a removed entry, one entry per cycle
         ST_SHIFT: begin
            if (idx_plus < count_ff) begin
               mem_we = 1'b1;
               idx_in = idx_plus;
            end else begin
               count_in  = count_ff - CNT_W'(1);
               status_in = STATUS_OK;
               state_in  = ST_STATUS;
            end
         end

         // Walk the entries: decrement or fire and reload
         ST_TICK: begin
            if (idx_ff == count_ff) begin
               state_in = ST_DONE;
            end else if (rd_entry.countdown != '0) begin
               mem_we              = 1'b1;
               mem_wdata.countdown = rd_entry.countdown - 32'd1;
               idx_in              = idx_plus;
            end else if (out_free) begin
               mem_we              = 1'b1;
               mem_wdata.countdown = rd_entry.reload;
               emit                = 1'b1;
               emit_data.kind      = KIND_FIRED;
               emit_data.fired_id  = rd_entry.timer_id;
               idx_in              = idx_plus;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               emit           = 1'b1;
               emit_data.kind = KIND_DONE;
               emit_data.last = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         ST_STATUS: begin
            if (out_free) begin
               emit             = 1'b1;
               emit_data.kind   = KIND_STATUS;
               emit_data.status = status_ff;
               emit_data.last   = 1'b1;
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
      rsp_in       = emit ? emit_data : rsp_ff;
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         status_ff    <= STATUS_OK;
         enabled_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
         enabled_ff   <= enabled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   // Timer entry storage
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_ff[mem_waddr[IDX_W-1:0]] <= mem_wdata;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
